/* sv/jittered_timer_delay_unit_assert.svh */
// Assertion macros for the jittered timer delay unit.
`ifndef JITTERED_TIMER_DELAY_UNIT_ASSERT_SVH
`define JITTERED_TIMER_DELAY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define JTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/jtd_pkg.sv */
// Types and constants shared by the jittered timer delay unit.
`default_nettype none

package jtd_pkg;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [1:0] MODE_MINUS = 2'd0;
	localparam logic [1:0] MODE_PLUS  = 2'd1;
	localparam logic [1:0] MODE_PM    = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [7:0]  PCT_MAX         = 8'd99;
	localparam logic [31:0] DIV_FIRST_LIMIT = 32'hffff_ffff / 32'd100;
	localparam logic [31:0] PCT_SCALE       = 32'd100;
	localparam logic [31:0] RANGE_MIN       = 32'd2;
	localparam int unsigned SEED_SHIFT      = 4;

	typedef struct packed {
		logic        op;
		logic [63:0] now_ms;
		logic [63:0] timer_value;
		logic [31:0] delay;
		logic [7:0]  jit_percent;
		logic [1:0]  jitter_mode;
	} jtd_in_t;

	typedef struct packed {
		logic [63:0] new_timer;
		logic [31:0] applied_delay;
		logic        changed;
	} jtd_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} jtd_div_sts_t;

endpackage

`default_nettype wire

/* sv/jtd_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module jtd_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [31:0]          dividend,
	input  wire logic [31:0]          divisor,
	output jtd_pkg::jtd_div_sts_t     sts,
	output logic      [31:0]          quotient,
	output logic      [31:0]          remainder
);

	localparam int W  = 32;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;

	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          qbit;

	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= qbit ? diff[W-1:0] : trial[W-1:0];
				dvd_q <= {dvd_q[W-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* sv/jittered_timer_delay_unit.sv */
// A stopped timer or a jitter percent above 99 goes from idle straight to the final state;
// a range below two skips the second divide; otherwise two divides run (range, then seed modulo range).
// Throughput: one request in flight; the next is accepted the cycle after the result loads,
// and the load waits while an earlier result is still held in the output register.
// Reset (arst_n low, asynchronous): seed cleared to zero, controller idle, no result valid.
`default_nettype none

module jittered_timer_delay_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire jtd_pkg::jtd_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output jtd_pkg::jtd_out_t     out_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_WAIT_Q,
		ST_RCHK,
		ST_MOD,
		ST_WAIT_J,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [63:0]        base_q;
	logic [31:0]        d_q;
	logic [7:0]         pct_q;
	logic [1:0]         mode_q;
	logic [31:0]        clk_low_q;
	logic [31:0]        seed_q;
	logic [31:0]        range_q;
	logic [31:0]        applied_q;
	logic               changed_q;
	logic               out_valid_q;
	jtd_pkg::jtd_out_t  out_q;

	jtd_pkg::jtd_div_sts_t div_sts;
	logic                  div_start;
	logic [31:0]           div_dividend;
	logic [31:0]           div_divisor;
	logic [31:0]           div_quo;
	logic [31:0]           div_rem;

	logic        accept;
	logic        is_update;
	logic        stopped;
	logic [31:0] d_eff;
	logic        div_first;
	logic        out_load;

	assign accept    = in_valid && in_ready;
	assign is_update = (in_data.op == jtd_pkg::OP_UPDATE);
	assign stopped   = is_update && (in_data.timer_value == 64'd0);
	assign d_eff     = (is_update && in_data.delay[31]) ? 32'd1 : in_data.delay;
	assign div_first = (d_q > jtd_pkg::DIV_FIRST_LIMIT);
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign div_start    = (state_q == ST_PREP) || (state_q == ST_MOD);
	assign div_dividend = (state_q == ST_MOD) ? seed_q :
	                      (div_first ? d_q : d_q * {24'd0, pct_q});
	assign div_divisor  = (state_q == ST_MOD) ? range_q : jtd_pkg::PCT_SCALE;

	jtd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			d_q         <= '0;
			pct_q       <= '0;
			mode_q      <= jtd_pkg::MODE_MINUS;
			clk_low_q   <= '0;
			seed_q      <= '0;
			range_q     <= '0;
			applied_q   <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						d_q       <= d_eff;
						pct_q     <= in_data.jit_percent;
						mode_q    <= is_update ? jtd_pkg::MODE_MINUS : in_data.jitter_mode;
						clk_low_q <= in_data.now_ms[31:0];
						base_q    <= stopped ? 64'd0 :
						             (is_update ? in_data.timer_value : in_data.now_ms);
						applied_q <= stopped ? 32'd0 : d_eff;
						changed_q <= ~stopped;
						if (stopped || (in_data.jit_percent > jtd_pkg::PCT_MAX)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					state_q <= ST_WAIT_Q;
				end
				ST_WAIT_Q: begin
					if (div_sts.done) begin
						range_q <= div_first ? div_quo * {24'd0, pct_q} : div_quo;
						state_q <= ST_RCHK;
					end
				end
				ST_RCHK: begin
					if (range_q < jtd_pkg::RANGE_MIN) begin
						state_q <= ST_FIN;
					end else begin
						seed_q  <= (seed_q << jtd_pkg::SEED_SHIFT) ^ clk_low_q;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_WAIT_J;
				end
				ST_WAIT_J: begin
					if (div_sts.done) begin
						case (mode_q)
							jtd_pkg::MODE_MINUS: applied_q <= d_q - div_rem;
							jtd_pkg::MODE_PLUS:  applied_q <= d_q + div_rem;
							jtd_pkg::MODE_PM:    applied_q <= d_q + div_rem - (range_q >> 1);
							default:             applied_q <= d_q;
						endcase
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_q.new_timer     <= base_q + {32'd0, applied_q};
						out_q.applied_delay <= applied_q;
						out_q.changed       <= changed_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "jittered_timer_delay_unit_assert.svh"

	`JTD_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_sts.busy, "divider busy while idle")
	`JTD_ASSERT_NOW(a_done_expected, div_sts.done,
		(state_q == ST_WAIT_Q) || (state_q == ST_WAIT_J), "divider done outside wait state")
	`JTD_ASSERT_NOW(a_stopped_zero, out_valid && !out_data.changed,
		(out_data.new_timer == 64'd0) && (out_data.applied_delay == 32'd0),
		"stopped timer result not zero")
	`JTD_ASSERT_NEXT(a_seed_on_rchk, !(state_q == ST_RCHK), $stable(seed_q),
		"seed changed outside range check")

endmodule

`default_nettype wire
